@@ src/fte_pkg.sv @@
package fte_pkg;

  localparam int unsigned ENTRY_W = 28;
  localparam int unsigned COUNT_W = 29;
  localparam int unsigned ASM_W   = 24;

  localparam logic [COUNT_W-1:0] MAX_TOTAL = 29'h1000_0000;

  localparam logic [ENTRY_W-1:0] BAD_MARK_12 = 28'h000_0FF7;
  localparam logic [ENTRY_W-1:0] BAD_MARK_16 = 28'h000_FFF7;
  localparam logic [ENTRY_W-1:0] BAD_MARK_32 = 28'hFFF_FFF7;
  localparam logic [ENTRY_W-1:0] EOC_MARK_12 = 28'h000_0FF8;
  localparam logic [ENTRY_W-1:0] EOC_MARK_16 = 28'h000_FFF8;
  localparam logic [ENTRY_W-1:0] EOC_MARK_32 = 28'hFFF_FFF8;
  localparam logic [ENTRY_W-1:0] LAST_RESERVED = 28'h000_0001;

  localparam logic REG_TABLE_TYPE    = 1'b0;
  localparam logic REG_CLUSTER_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_t;

  typedef enum logic [1:0] {
    CLASS_FREE = 2'd0,
    CLASS_BAD  = 2'd1,
    CLASS_USED = 2'd2
  } entry_class_t;

endpackage

@@ src/fat_table_entry_scanner.sv @@
// Decodes the raw bytes of one file allocation table, one byte per input beat, into
// FAT12, FAT16 or FAT32 entries as set by table_type, and gives one result beat per
// completed entry whose index is below cluster_total (clipped to 2^28), with its class,
// chain-end flag and running free, bad and allocated counts. The byte assembly, entry
// decode and count updates sit between the input handshake and a single output
// register, so a new byte is taken in every cycle while the output register is empty
// or being drained. A beat with start_of_table set restarts the table.
// Configuration must be written only while the block is idle.
module fat_table_entry_scanner
  import fte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           table_byte,
  input  logic                 start_of_table,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ENTRY_W-1:0]   entry_index,
  output logic [ENTRY_W-1:0]   entry_value,
  output logic [1:0]           entry_class,
  output logic                 ends_chain,
  output logic [COUNT_W-1:0]   free_count,
  output logic [COUNT_W-1:0]   bad_count,
  output logic [COUNT_W-1:0]   used_count,
  output logic                 final_entry
);

  logic [1:0]         table_type;
  logic [COUNT_W-1:0] cluster_total;

  logic [COUNT_W-1:0] next_entry_position;
  logic [1:0]         byte_phase;
  logic [ASM_W-1:0]   assembly_bytes;
  logic [COUNT_W-1:0] free_tally;
  logic [COUNT_W-1:0] bad_tally;
  logic [COUNT_W-1:0] used_tally;

  logic [COUNT_W-1:0] next_entry_position_next;
  logic [1:0]         byte_phase_next;
  logic [ASM_W-1:0]   assembly_bytes_next;
  logic [COUNT_W-1:0] free_tally_next;
  logic [COUNT_W-1:0] bad_tally_next;
  logic [COUNT_W-1:0] used_tally_next;

  fat_kind_t          kind;
  logic [1:0]         last_phase;
  logic [1:0]         phase;
  logic [COUNT_W-1:0] pos_base;
  logic [ASM_W-1:0]   asm_base;
  logic [COUNT_W-1:0] free_base;
  logic [COUNT_W-1:0] bad_base;
  logic [COUNT_W-1:0] used_base;
  logic [ENTRY_W-1:0] value;
  logic               done;
  logic [COUNT_W-1:0] total;
  logic               emit;
  logic [ENTRY_W-1:0] bad_mark;
  logic [ENTRY_W-1:0] eoc_mark;
  logic               is_bad;
  entry_class_t       cls;
  logic               chain_end;
  logic               is_final;
  logic               in_accept;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    case (table_type)
      2'd0:    kind = KIND_FAT12;
      2'd1:    kind = KIND_FAT16;
      default: kind = KIND_FAT32;
    endcase

    case (kind)
      KIND_FAT12: begin
        last_phase = 2'd2;
        bad_mark   = BAD_MARK_12;
        eoc_mark   = EOC_MARK_12;
      end
      KIND_FAT16: begin
        last_phase = 2'd1;
        bad_mark   = BAD_MARK_16;
        eoc_mark   = EOC_MARK_16;
      end
      default: begin
        last_phase = 2'd3;
        bad_mark   = BAD_MARK_32;
        eoc_mark   = EOC_MARK_32;
      end
    endcase

    pos_base  = start_of_table ? '0 : next_entry_position;
    asm_base  = start_of_table ? '0 : assembly_bytes;
    free_base = start_of_table ? '0 : free_tally;
    bad_base  = start_of_table ? '0 : bad_tally;
    used_base = start_of_table ? '0 : used_tally;
    phase     = start_of_table ? 2'd0 : byte_phase;
    if (phase > last_phase) begin
      phase = last_phase;
    end

    value = '0;
    done  = 1'b0;
    case (kind)
      KIND_FAT12: begin
        if (phase == 2'd1) begin
          value = {16'd0, table_byte[3:0], asm_base[7:0]};
          done  = 1'b1;
        end else if (phase == 2'd2) begin
          value = {16'd0, table_byte, asm_base[15:12]};
          done  = 1'b1;
        end
      end
      KIND_FAT16: begin
        if (phase == 2'd1) begin
          value = {12'd0, table_byte, asm_base[7:0]};
          done  = 1'b1;
        end
      end
      default: begin
        if (phase == 2'd3) begin
          value = {table_byte[3:0], asm_base};
          done  = 1'b1;
        end
      end
    endcase

    if (phase == last_phase) begin
      byte_phase_next     = 2'd0;
      assembly_bytes_next = '0;
    end else begin
      byte_phase_next     = phase + 2'd1;
      assembly_bytes_next = asm_base;
      case (phase)
        2'd0:    assembly_bytes_next[7:0]   = asm_base[7:0] | table_byte;
        2'd1:    assembly_bytes_next[15:8]  = asm_base[15:8] | table_byte;
        default: assembly_bytes_next[23:16] = asm_base[23:16] | table_byte;
      endcase
    end

    total     = (cluster_total > MAX_TOTAL) ? MAX_TOTAL : cluster_total;
    emit      = done && (pos_base < total);
    is_bad    = (value == bad_mark);
    chain_end = (value <= LAST_RESERVED) || is_bad || (value >= eoc_mark);
    is_final  = ((pos_base + 29'd1) == total);

    next_entry_position_next = pos_base;
    free_tally_next          = free_base;
    bad_tally_next           = bad_base;
    used_tally_next          = used_base;
    if (value == '0) begin
      cls = CLASS_FREE;
    end else if (is_bad) begin
      cls = CLASS_BAD;
    end else begin
      cls = CLASS_USED;
    end
    if (emit) begin
      next_entry_position_next = pos_base + 29'd1;
      case (cls)
        CLASS_FREE: free_tally_next = free_base + 29'd1;
        CLASS_BAD:  bad_tally_next  = bad_base + 29'd1;
        default:    used_tally_next = used_base + 29'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_type          <= 2'd0;
      cluster_total       <= '0;
      next_entry_position <= '0;
      byte_phase          <= 2'd0;
      assembly_bytes      <= '0;
      free_tally          <= '0;
      bad_tally           <= '0;
      used_tally          <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TABLE_TYPE:    table_type    <= cfg_data[1:0];
          REG_CLUSTER_TOTAL: cluster_total <= cfg_data;
          default:           ;
        endcase
      end
      if (in_accept) begin
        next_entry_position <= next_entry_position_next;
        byte_phase          <= byte_phase_next;
        assembly_bytes      <= assembly_bytes_next;
        free_tally          <= free_tally_next;
        bad_tally           <= bad_tally_next;
        used_tally          <= used_tally_next;
        out_valid           <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      entry_index <= pos_base[ENTRY_W-1:0];
      entry_value <= value;
      entry_class <= cls;
      ends_chain  <= chain_end;
      free_count  <= free_tally_next;
      bad_count   <= bad_tally_next;
      used_count  <= used_tally_next;
      final_entry <= is_final;
    end
  end

endmodule

@@ src/fte_checker.sv @@
module fte_checker
  import fte_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ENTRY_W-1:0] entry_index,
  input logic [ENTRY_W-1:0] entry_value,
  input logic [1:0]         entry_class,
  input logic               ends_chain,
  input logic [COUNT_W-1:0] free_count,
  input logic [COUNT_W-1:0] bad_count,
  input logic [COUNT_W-1:0] used_count
);

  // A result beat that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_index) && $stable(entry_value))
    else $error("result beat changed while stalled");

  // The three counts together cover every entry up to and including this one.
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, free_count} + {1'b0, bad_count} + {1'b0, used_count})
                  == ({2'b0, entry_index} + 30'd1))
    else $error("counts do not add up to the entry index");

  // A free entry has a zero value, and a zero value always ends a chain.
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_class == CLASS_FREE |-> entry_value == '0 && ends_chain)
    else $error("free entry with nonzero value or open chain");

  // The input side is only held off by a full output register that is not drained.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result beat");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind fat_table_entry_scanner fte_checker u_fte_checker (.*);

@@ dv/fat_table_entry_scanner_tb.sv @@
`timescale 1ns / 1ps
module fat_table_entry_scanner_tb;
  import fte_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic [ENTRY_W-1:0] entry_value;
    entry_class_t       entry_class;
    logic               ends_chain;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] bad_count;
    logic [COUNT_W-1:0] used_count;
    logic               final_entry;
  } entry_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_index = REG_TABLE_TYPE;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         table_byte = 8'h00;
  logic               start_of_table = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ENTRY_W-1:0] entry_index;
  logic [ENTRY_W-1:0] entry_value;
  logic [1:0]         entry_class;
  logic               ends_chain;
  logic [COUNT_W-1:0] free_count;
  logic [COUNT_W-1:0] bad_count;
  logic [COUNT_W-1:0] used_count;
  logic               final_entry;

  fat_table_entry_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .table_byte    (table_byte),
    .start_of_table(start_of_table),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .entry_class   (entry_class),
    .ends_chain    (ends_chain),
    .free_count    (free_count),
    .bad_count     (bad_count),
    .used_count    (used_count),
    .final_entry   (final_entry)
  );

  // Mirror of the block's configuration and scan state.
  logic [1:0]         type_cfg = 2'd0;
  logic [COUNT_W-1:0] total_cfg = '0;
  logic [COUNT_W-1:0] next_pos = '0;
  logic [1:0]         phase_q = 2'd0;
  logic [ASM_W-1:0]   asm_q = '0;
  logic [COUNT_W-1:0] free_tally = '0;
  logic [COUNT_W-1:0] bad_tally = '0;
  logic [COUNT_W-1:0] used_tally = '0;

  entry_result_t expected_entries[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int entries_checked = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 56;
  int stall_request = 0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void kind_marks(input logic [1:0] kind, output logic [ENTRY_W-1:0] bad,
                                     output logic [ENTRY_W-1:0] eoc,
                                     output logic [ENTRY_W-1:0] mask);
    case (kind)
      KIND_FAT12: begin
        bad = BAD_MARK_12;
        eoc = EOC_MARK_12;
        mask = 28'h000_0FFF;
      end
      KIND_FAT16: begin
        bad = BAD_MARK_16;
        eoc = EOC_MARK_16;
        mask = 28'h000_FFFF;
      end
      default: begin
        bad = BAD_MARK_32;
        eoc = EOC_MARK_32;
        mask = 28'hFFF_FFFF;
      end
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic sot);
    int unsigned        last;
    int unsigned        ph;
    logic               done;
    logic [ENTRY_W-1:0] value;
    logic [ENTRY_W-1:0] bad;
    logic [ENTRY_W-1:0] eoc;
    logic [ENTRY_W-1:0] mask;
    logic [COUNT_W-1:0] total;
    entry_result_t      r;
    if (sot) begin
      next_pos = '0;
      phase_q = 2'd0;
      asm_q = '0;
      free_tally = '0;
      bad_tally = '0;
      used_tally = '0;
    end
    last = (type_cfg == KIND_FAT12) ? 2 : ((type_cfg == KIND_FAT16) ? 1 : 3);
    ph = phase_q;
    if (ph > last) ph = last;
    done = 1'b0;
    value = '0;
    case (type_cfg)
      KIND_FAT12: begin
        if (ph == 1) begin
          value = {16'd0, b[3:0], asm_q[7:0]};
          done = 1'b1;
        end else if (ph == 2) begin
          value = {16'd0, b, asm_q[15:12]};
          done = 1'b1;
        end
      end
      KIND_FAT16: begin
        if (ph == 1) begin
          value = {12'd0, b, asm_q[7:0]};
          done = 1'b1;
        end
      end
      default: begin
        if (ph == 3) begin
          value = {b[3:0], asm_q};
          done = 1'b1;
        end
      end
    endcase
    if (ph == last) begin
      phase_q = 2'd0;
      asm_q = '0;
    end else begin
      asm_q = asm_q | (24'(b) << (8 * ph));
      phase_q = 2'(ph + 1);
    end
    if (!done) return;
    total = (total_cfg > MAX_TOTAL) ? MAX_TOTAL : total_cfg;
    if (next_pos >= total) return;
    kind_marks(type_cfg, bad, eoc, mask);
    r.entry_index = next_pos[ENTRY_W-1:0];
    r.entry_value = value;
    if (value == '0) begin
      r.entry_class = CLASS_FREE;
      free_tally++;
    end else if (value == bad) begin
      r.entry_class = CLASS_BAD;
      bad_tally++;
    end else begin
      r.entry_class = CLASS_USED;
      used_tally++;
    end
    r.ends_chain = (value <= LAST_RESERVED) || (value == bad) || (value >= eoc);
    r.free_count = free_tally;
    r.bad_count = bad_tally;
    r.used_count = used_tally;
    r.final_entry = (next_pos + 29'd1 == total);
    next_pos++;
    expected_entries = {expected_entries, r};
  endfunction

  function automatic string describe(entry_result_t r);
    return $sformatf("index %0d value %h class %0d end %b free %0d bad %0d used %0d final %b",
                     r.entry_index, r.entry_value, r.entry_class, r.ends_chain, r.free_count,
                     r.bad_count, r.used_count, r.final_entry);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    entry_result_t want;
    entry_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.entry_index = entry_index;
      got.entry_value = entry_value;
      got.entry_class = entry_class_t'(entry_class);
      got.ends_chain = ends_chain;
      got.free_count = free_count;
      got.bad_count = bad_count;
      got.used_count = used_count;
      got.final_entry = final_entry;
      if (expected_entries.size() == 0) begin
        note_failure($sformatf("Result beat with nothing expected: %s", describe(got)));
      end else begin
        want = expected_entries.pop_front();
        entries_checked++;
        if (got !== want)
          note_failure($sformatf("Mismatch: expected %s, got %s", describe(want),
                                 describe(got)));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    table_byte <= b;
    start_of_table <= sot;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, sot);
    bytes_sent++;
  endtask

  task automatic send_entries(input logic [1:0] kind, input logic [ENTRY_W-1:0] vals[$],
                              input logic sot);
    logic [7:0]         stream_q[$];
    logic [ENTRY_W-1:0] odd_val;
    if (kind == KIND_FAT12) begin
      for (int i = 0; i < vals.size(); i += 2) begin
        odd_val = (i + 1 < vals.size()) ? vals[i+1] : 28'($urandom_range(12'hFFF));
        stream_q = {stream_q, vals[i][7:0]};
        stream_q = {stream_q, {odd_val[3:0], vals[i][11:8]}};
        stream_q = {stream_q, odd_val[11:4]};
      end
    end else if (kind == KIND_FAT16) begin
      foreach (vals[i]) begin
        stream_q = {stream_q, vals[i][7:0]};
        stream_q = {stream_q, vals[i][15:8]};
      end
    end else begin
      foreach (vals[i]) begin
        stream_q = {stream_q, vals[i][7:0]};
        stream_q = {stream_q, vals[i][15:8]};
        stream_q = {stream_q, vals[i][23:16]};
        stream_q = {stream_q, {4'($urandom), vals[i][27:24]}};
      end
    end
    foreach (stream_q[j]) send_byte(stream_q[j], sot && (j == 0));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [COUNT_W-1:0] data);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TABLE_TYPE) type_cfg = data[1:0];
    else total_cfg = data;
  endtask

  // Free, bad and end-of-chain marks, with the last entry lying past the count.
  task automatic test_fat12_marks();
    write_register(REG_TABLE_TYPE, 29'(KIND_FAT12));
    write_register(REG_CLUSTER_TOTAL, 29'd3);
    send_entries(KIND_FAT12, '{28'h000, 28'hFF7, 28'hFF8, 28'hFFF}, 1'b1);
  endtask

  // A restart in the middle of an entry, then the reserved and top values.
  task automatic test_fat16_restart();
    write_register(REG_TABLE_TYPE, 29'(KIND_FAT16));
    write_register(REG_CLUSTER_TOTAL, 29'd3);
    send_byte(8'h77, 1'b1);
    send_entries(KIND_FAT16, '{28'h0001, 28'hFFF7, 28'hFFFF}, 1'b1);
  endtask

  // The spare type code decodes as FAT32, and the count is clipped to 2^28.
  task automatic test_fat32_spare_code();
    write_register(REG_TABLE_TYPE, 29'(KIND_UNUSED));
    write_register(REG_CLUSTER_TOTAL, 29'h1FFF_FFFF);
    send_entries(KIND_UNUSED, '{28'hFFF_FFF7, 28'hFFF_FFF8, 28'h000_0002}, 1'b1);
  endtask

  // Switching to a shorter format while an entry is half built completes it.
  task automatic test_type_change_mid_entry();
    write_register(REG_TABLE_TYPE, 29'(KIND_FAT32));
    write_register(REG_CLUSTER_TOTAL, 29'd4);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    write_register(REG_TABLE_TYPE, 29'(KIND_FAT16));
    send_byte(8'hC3, 1'b0);
    send_entries(KIND_FAT16, '{28'h0000}, 1'b0);
  endtask

  task automatic test_output_backpressure();
    logic [ENTRY_W-1:0] vals[$];
    write_register(REG_TABLE_TYPE, 29'(KIND_FAT16));
    write_register(REG_CLUSTER_TOTAL, 29'd40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) vals = {vals, 28'($urandom_range(16'hFFFF))};
    stall_request = 150;
    send_entries(KIND_FAT16, vals, 1'b1);
  endtask

  task automatic test_random_tables(input int n_bytes, input int s_pct, input int r_pct);
    logic [1:0]         kind;
    logic [COUNT_W-1:0] total;
    logic [ENTRY_W-1:0] bad;
    logic [ENTRY_W-1:0] eoc;
    logic [ENTRY_W-1:0] mask;
    logic [ENTRY_W-1:0] vals[$];
    int                 first_byte;
    int                 count;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < n_bytes) begin
      kind = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: total = '0;
        1: total = MAX_TOTAL;
        2: total = 29'h1FFF_FFFF;
        3: total = 29'($urandom);
        default: total = 29'($urandom_range(1, 40));
      endcase
      write_register(REG_TABLE_TYPE, 29'(kind));
      write_register(REG_CLUSTER_TOTAL, total);
      kind_marks(kind, bad, eoc, mask);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(9))
          7, 8: begin
            send_byte(8'($urandom), 1'b1);
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(7) == 0);
          end
          9: begin
            repeat ($urandom_range(1, 7)) send_byte(8'($urandom), $urandom_range(3) == 0);
          end
          default: begin
            vals.delete();
            count = $urandom_range(1, 48);
            repeat (count) begin
              case ($urandom_range(7))
                0: vals = {vals, 28'd0};
                1: vals = {vals, bad};
                2: vals = {vals, (eoc + 28'($urandom_range(7))) & mask};
                3: vals = {vals, 28'($urandom_range(2))};
                default: vals = {vals, 28'($urandom) & mask};
              endcase
            end
            send_entries(kind, vals, 1'b1);
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_fat12_marks();
    test_fat16_restart();
    test_fat32_spare_code();
    test_type_change_mid_entry();
    test_random_tables(300, 9, 56);
    test_random_tables(300, 56, 9);
    test_output_backpressure();
    test_random_tables(300, 0, 0);
    wait_idle();
    $display("Sent %0d table bytes and checked %0d entries over FAT12, FAT16, FAT32",
             bytes_sent, entries_checked);
    $display("and the spare code, with zero and clipped counts, a format switch mid-entry");
    $display("and a long output stall.");
    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/fte_pkg.sv
src/fat_table_entry_scanner.sv
src/fte_checker.sv
dv/fat_table_entry_scanner_tb.sv
